FILE: hw/rtl/i2c_fram_transaction_master_top_defines.svh
// Assertion macros for the I2C FRAM master.
`ifndef I2C_FRAM_TRANSACTION_MASTER_TOP_DEFINES_SVH
`define I2C_FRAM_TRANSACTION_MASTER_TOP_DEFINES_SVH
// Check that a property holds on every clock edge outside reset.
`define IFM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a consequence on the next edge.
`define IFM_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);
`endif

FILE: hw/rtl/ifm_pkg.sv
// Package for the I2C FRAM master: opcodes, config indices, phases, stages, the result beat and defaults.
package ifm_pkg;
	localparam int MaxBytesDef = 512;
	localparam int MemBytesDef = 2048;
	localparam logic [15:0] HalfResetVal = 16'd50;
	localparam logic [15:0] SetupResetVal = 16'd30;
	localparam logic [7:0] DevBase = 8'hA0;
	localparam int CfgIdxW = 1;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ = 2'd2,
		OP_PUSH = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		CFG_HALF = 1'b0,
		CFG_SETUP = 1'b1
	} cfg_idx_t;

	typedef enum logic [15:0] {
		PH_IDLE = 16'h0001,
		PH_START_HI = 16'h0002,
		PH_START_LO = 16'h0004,
		PH_TX_LOW = 16'h0008,
		PH_TX_SETUP = 16'h0010,
		PH_TX_HIGH = 16'h0020,
		PH_TXACK_LOW = 16'h0040,
		PH_TXACK_HIGH = 16'h0080,
		PH_RX_LOW = 16'h0100,
		PH_RX_HIGH = 16'h0200,
		PH_RXACK_LOW = 16'h0400,
		PH_RXACK_SETUP = 16'h0800,
		PH_RXACK_HIGH = 16'h1000,
		PH_RESTART_LOW = 16'h2000,
		PH_STOP_LOW = 16'h4000,
		PH_STOP_HIGH = 16'h8000
	} phase_t;

	typedef enum logic [1:0] {
		STG_DEV_W = 2'd0,
		STG_ADDR_LO = 2'd1,
		STG_DATA = 2'd2,
		STG_DEV_R = 2'd3
	} stage_t;

	// one result beat
	typedef struct packed {
		logic scl;
		logic sda;
		logic [7:0] rbyte;
		logic rvalid;
		logic done;
		logic status;
		logic busy;
	} res_t;
endpackage

FILE: hw/rtl/ifm_ram.sv
// Generic single-port-write, registered-read RAM.
module ifm_ram #(
	parameter int Width = 8,
	parameter int Depth = 512
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic re,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: hw/rtl/ifm_front.sv
// Front end: accepts items and buffers them in a short queue toward the engine.
module ifm_front #(
	parameter int Depth = 2
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] op,
	input logic [10:0] mem_address,
	input logic [9:0] byte_count,
	input logic [7:0] write_byte,
	input logic sda_in,
	output logic q_valid,
	input logic q_pop,
	output logic [31:0] q_data
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	logic [31:0] ent_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != (AW+1)'(Depth));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_data = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= {op, mem_address, byte_count, write_byte, sda_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			end
			if (q_pop) begin
				rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

FILE: hw/rtl/ifm_engine.sv
// Back end: bus engine that runs one queued item a cycle while its output register is free or draining.
module ifm_engine #(
	parameter int MaxBytes = 512,
	parameter int MemBytes = 2048
) (
	input logic clk,
	input logic arst_n,
	input logic [15:0] half_q,
	input logic [15:0] setup_q,
	input logic q_valid,
	output logic q_pop,
	input logic [31:0] q_data,
	output logic out_valid,
	input logic out_ready,
	output ifm_pkg::res_t res
);
	import ifm_pkg::*;
	localparam int PW = $clog2(MaxBytes + 1);
	localparam int BAW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
	localparam int MAW = $clog2(MemBytes);

	logic [1:0] op;
	logic [10:0] addr_in;
	logic [9:0] cnt_in;
	logic [7:0] wb_in;
	logic sda_in;
	assign {op, addr_in, cnt_in, wb_in, sda_in} = q_data;

	phase_t phase_q;
	stage_t stage_q;
	logic [15:0] tick_q;
	logic [3:0] bit_q;
	logic [7:0] shift_q;
	logic [PW-1:0] left_q, fill_q, rptr_q;
	logic [10:0] addr_q;
	logic is_read_q, failed_q, scl_q, sda_q;
	logic out_valid_q;
	res_t res_q;

	// One buffer byte is prefetched into the RAM read register one
	// step ahead of its use: rptr_q always addresses the next byte.
	logic [7:0] rdata;
	logic ram_we, ram_re;

	// Output register: take a new item when empty or draining.
	logic fire;
	assign fire = q_valid && (!out_valid_q || out_ready);
	assign q_pop = fire;
	assign out_valid = out_valid_q;
	assign res = res_q;

	// next-state
	phase_t ph_n;
	stage_t st_n;
	logic [15:0] tick_n;
	logic [3:0] bit_n;
	logic [7:0] sh_n, rb_n;
	logic [PW-1:0] left_n, fill_n, rptr_n;
	logic [10:0] addr_n;
	logic rd_n, fail_n, scl_n, sda_n, rv_n, dn_n;
	logic [16:0] dur;
	logic [PW-1:0] cnt_sat;
	logic [7:0] devb;
	logic rptr_adv;

	always_comb begin
		if (cnt_in == '0) cnt_sat = PW'(1);
		else if (32'(cnt_in) > MaxBytes) cnt_sat = PW'(MaxBytes);
		else cnt_sat = PW'(cnt_in);
	end

	assign devb = DevBase | {4'b0, addr_q[10:8], 1'b0} | {7'b0, stage_q == STG_DEV_R};

	always_comb begin
		ph_n = phase_q; st_n = stage_q; tick_n = tick_q; bit_n = bit_q;
		sh_n = shift_q; left_n = left_q; fill_n = fill_q; rptr_n = rptr_q;
		addr_n = addr_q; rd_n = is_read_q; fail_n = failed_q;
		scl_n = scl_q; sda_n = sda_q; rv_n = 1'b0; dn_n = 1'b0; rb_n = '0;
		rptr_adv = 1'b0;
		ram_we = 1'b0;
		if (phase_q == PH_TX_SETUP || phase_q == PH_RXACK_SETUP) dur = {1'b0, setup_q};
		else dur = (half_q == '0) ? 17'd1 : {1'b0, half_q};
		if (op == OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				if ({1'b0, tick_q} + 17'd1 < dur) begin
					tick_n = tick_q + 16'd1;
				end else begin
					tick_n = '0;
					unique case (phase_q)
						PH_START_HI: begin ph_n = PH_START_LO; scl_n = 1'b1; sda_n = 1'b0; end
						PH_START_LO: begin
							sh_n = devb; bit_n = '0; ph_n = PH_TX_LOW; scl_n = 1'b0; sda_n = 1'b0;
						end
						PH_TX_LOW: begin
							sda_n = shift_q[7];
							if (setup_q != '0) begin ph_n = PH_TX_SETUP; scl_n = 1'b0; end
							else begin ph_n = PH_TX_HIGH; scl_n = 1'b1; end
						end
						PH_TX_SETUP: begin ph_n = PH_TX_HIGH; scl_n = 1'b1; end
						PH_TX_HIGH: begin
							sh_n = {shift_q[6:0], 1'b0};
							bit_n = bit_q + 4'd1;
							scl_n = 1'b0;
							ph_n = (bit_q + 4'd1 >= 4'd8) ? PH_TXACK_LOW : PH_TX_LOW;
						end
						PH_TXACK_LOW: begin ph_n = PH_TXACK_HIGH; scl_n = 1'b1; sda_n = 1'b1; end
						PH_TXACK_HIGH: begin
							scl_n = 1'b0;
							if (sda_in) begin
								fail_n = 1'b1; ph_n = PH_STOP_LOW; sda_n = 1'b0;
							end else begin
								sda_n = 1'b1;
								unique case (stage_q)
									STG_DEV_W: begin
										st_n = STG_ADDR_LO; sh_n = addr_q[7:0]; bit_n = '0;
										ph_n = PH_TX_LOW;
									end
									STG_ADDR_LO: begin
										if (is_read_q) begin
											st_n = STG_DEV_R; ph_n = PH_RESTART_LOW;
										end else begin
											st_n = STG_DATA;
											sh_n = rdata; rptr_adv = 1'b1;
											if (left_q != '0) left_n = left_q - 1'b1;
											bit_n = '0; ph_n = PH_TX_LOW;
										end
									end
									STG_DATA: begin
										if (left_q == '0) begin
											ph_n = PH_STOP_LOW; sda_n = 1'b0;
										end else begin
											sh_n = rdata; rptr_adv = 1'b1;
											left_n = left_q - 1'b1;
											bit_n = '0; ph_n = PH_TX_LOW;
										end
									end
									default: begin bit_n = '0; ph_n = PH_RX_LOW; end
								endcase
							end
						end
						PH_RX_LOW: begin ph_n = PH_RX_HIGH; scl_n = 1'b1; sda_n = 1'b1; end
						PH_RX_HIGH: begin
							sh_n = {shift_q[6:0], sda_in};
							bit_n = bit_q + 4'd1;
							scl_n = 1'b0; sda_n = 1'b1;
							if (bit_q + 4'd1 >= 4'd8) begin
								rv_n = 1'b1; rb_n = {shift_q[6:0], sda_in};
								if (left_q != '0) left_n = left_q - 1'b1;
								ph_n = PH_RXACK_LOW;
							end else begin
								ph_n = PH_RX_LOW;
							end
						end
						PH_RXACK_LOW: begin
							sda_n = (left_q == '0);
							if (setup_q != '0) begin ph_n = PH_RXACK_SETUP; scl_n = 1'b0; end
							else begin ph_n = PH_RXACK_HIGH; scl_n = 1'b1; end
						end
						PH_RXACK_SETUP: begin ph_n = PH_RXACK_HIGH; scl_n = 1'b1; end
						PH_RXACK_HIGH: begin
							scl_n = 1'b0;
							if (left_q == '0) begin
								ph_n = PH_STOP_LOW; sda_n = 1'b0;
							end else begin
								bit_n = '0; ph_n = PH_RX_LOW; sda_n = 1'b1;
							end
						end
						PH_RESTART_LOW: begin ph_n = PH_START_HI; scl_n = 1'b1; sda_n = 1'b1; end
						PH_STOP_LOW: begin ph_n = PH_STOP_HIGH; scl_n = 1'b1; sda_n = 1'b0; end
						default: begin
							dn_n = 1'b1;
							if (!is_read_q) fill_n = '0;
							ph_n = PH_IDLE; scl_n = 1'b1; sda_n = 1'b1;
						end
					endcase
				end
			end
		end else if (phase_q == PH_IDLE) begin
			if (op == OP_PUSH) begin
				if (32'(fill_q) < MaxBytes) begin
					ram_we = 1'b1;
					fill_n = fill_q + 1'b1;
				end
			end else begin
				addr_n = 11'(addr_in[MAW-1:0]);
				left_n = cnt_sat;
				rd_n = (op == OP_READ);
				rptr_n = '0;
				rptr_adv = 1'b0;
				st_n = STG_DEV_W;
				fail_n = 1'b0;
				bit_n = '0;
				tick_n = '0;
				ph_n = PH_START_HI; scl_n = 1'b1; sda_n = 1'b1;
			end
		end
		if (rptr_adv) rptr_n = rptr_q + 1'b1;
	end

	// Read address: next byte to send; refreshed each beat so pushes to
	// entry rptr are visible, and advances are seen one beat early.
	logic [BAW-1:0] raddr;
	assign raddr = BAW'(rptr_n);
	assign ram_re = fire;

	ifm_ram #(.Width(8), .Depth(MaxBytes)) u_buf (
		.clk(clk),
		.we(fire && ram_we),
		.waddr(BAW'(fill_q)),
		.wdata(wb_in),
		.re(ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; stage_q <= STG_DEV_W; tick_q <= '0; bit_q <= '0;
			shift_q <= '0; left_q <= '0; fill_q <= '0; rptr_q <= '0; addr_q <= '0;
			is_read_q <= 1'b0; failed_q <= 1'b0; scl_q <= 1'b1; sda_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= ph_n; stage_q <= st_n; tick_q <= tick_n; bit_q <= bit_n;
				shift_q <= sh_n; left_q <= left_n; fill_q <= fill_n; rptr_q <= rptr_n;
				addr_q <= addr_n; is_read_q <= rd_n; failed_q <= fail_n;
				scl_q <= scl_n; sda_q <= sda_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			// a tick shows levels before it; a command shows levels after it
			res_q.scl <= (op == OP_TICK) ? scl_q : scl_n;
			res_q.sda <= (op == OP_TICK) ? sda_q : sda_n;
			res_q.rbyte <= rb_n;
			res_q.rvalid <= rv_n;
			res_q.done <= dn_n;
			res_q.status <= dn_n & fail_n;
			res_q.busy <= (ph_n != PH_IDLE);
		end
	end
endmodule

FILE: hw/rtl/i2c_fram_transaction_master_top.sv
// Top level of the tick-driven I2C master for an 11-bit-addressed FRAM.
// Usage:
//  - Input channel (in_valid/in_ready) takes one beat per item: op selects
//    tick, begin write, begin read or push of a write byte. Each tick item
//    advances the bus engine by one timing step; commands do not.
//  - Output channel (out_valid/out_ready) returns exactly one beat per item
//    with the SCL/SDA levels, a received byte, done and status, busy.
//  - Config port: cfg_we writes register cfg_index (0 half period, 1 setup)
//    with cfg_wdata; write only while no item is in flight.
// Path: an item's result passes the queue stage, then the engine's
// output register.
// Throughput: one item per cycle while out_ready keeps the output draining;
// the engine retires one queued item each cycle, and its output register
// takes a new result while the old one is being taken in the same cycle.
// Stall: if out_ready stays low, the engine holds and the two-entry queue
// fills, then in_ready drops.
// Reset: arst_n clears the engine to idle, SCL/SDA released, counters and
// pointers to zero, registers to 50 and 30 ticks; the buffer is unset.
module i2c_fram_transaction_master_top
	import ifm_pkg::*;
#(
	parameter int MaxBytes = ifm_pkg::MaxBytesDef,
	parameter int MemBytes = ifm_pkg::MemBytesDef
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] op,
	input logic [10:0] mem_address,
	input logic [9:0] byte_count,
	input logic [7:0] write_byte,
	input logic sda_in,
	output logic out_valid,
	input logic out_ready,
	output logic scl_out,
	output logic sda_out,
	output logic [7:0] read_byte,
	output logic read_valid,
	output logic done_res,
	output logic status,
	output logic busy_res,
	input logic cfg_we,
	input logic [ifm_pkg::CfgIdxW-1:0] cfg_index,
	input logic [15:0] cfg_wdata
);
	`include "i2c_fram_transaction_master_top_defines.svh"

	logic [15:0] half_q, setup_q;
	logic q_valid, q_pop;
	logic [31:0] q_data;
	res_t res;

	// hold configuration; the user must write it only when idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HalfResetVal;
			setup_q <= SetupResetVal;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HALF: half_q <= cfg_wdata;
				CFG_SETUP: setup_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ifm_front #(.Depth(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .mem_address(mem_address), .byte_count(byte_count),
		.write_byte(write_byte), .sda_in(sda_in),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	ifm_engine #(.MaxBytes(MaxBytes), .MemBytes(MemBytes)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.half_q(half_q), .setup_q(setup_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign scl_out = res.scl;
	assign sda_out = res.sda;
	assign read_byte = res.rbyte;
	assign read_valid = res.rvalid;
	assign done_res = res.done;
	assign status = res.status;
	assign busy_res = res.busy;

	// pop the queue only when it holds an item
	`IFM_ASSERT(a_pop_ok, !q_pop || q_valid, "pop from empty queue")
	// a popped item always produces a result beat next cycle
	`IFM_ASSERT_NEXT(a_pop_res, q_pop, out_valid, "popped item gave no result")
	// a done beat never also reports busy
	`IFM_ASSERT(a_done_idle, !(out_valid && done_res && busy_res), "done while busy")
endmodule

FILE: dv/i2c_fram_transaction_master_top_test.sv
// Self-checking testbench for the tick-driven I2C FRAM transaction master.
module i2c_fram_transaction_master_top_test;
	import ifm_pkg::*;

	// Bus stimulus runs with short timing so that whole transfers fit in the
	// run; the slow reset timing is seen only by the opening rows.

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_TICK;
	logic [10:0] mem_address = '0;
	logic [9:0] byte_count = '0;
	logic [7:0] write_byte = '0;
	logic sda_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic scl_out, sda_out, read_valid, done_res, status, busy_res;
	logic [7:0] read_byte;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = CFG_HALF;
	logic [15:0] cfg_wdata = '0;

	i2c_fram_transaction_master_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .mem_address(mem_address), .byte_count(byte_count),
		.write_byte(write_byte), .sda_in(sda_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.scl_out(scl_out), .sda_out(sda_out), .read_byte(read_byte),
		.read_valid(read_valid), .done_res(done_res), .status(status),
		.busy_res(busy_res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// ---------------- bus engine predictor ----------------
	localparam int BufDepth = 512;

	logic [15:0] half_q, setup_q;
	phase_t bus_ph;
	stage_t bus_stg;
	logic [15:0] bus_tcnt;
	logic [3:0] bus_bidx;
	logic [7:0] bus_shift;
	logic [9:0] bus_left;
	logic [10:0] bus_addr;
	logic bus_rd, bus_scl, bus_sda, bus_failed;
	logic [7:0] wbuf [BufDepth];
	int fill_ptr, data_ptr;
	int pushed_hi;          // entries 0..pushed_hi-1 have been written at least once

	res_t beat_q[$];        // expected result beats, oldest first
	int errors = 0;
	int accepted = 0;
	bit typed_on = 1'b0;
	res_t typed_res = '0;
	int send_idle = 0, recv_idle = 0;

	function automatic void go_to(phase_t p, logic c, logic d);
		bus_ph = p;
		bus_tcnt = '0;
		bus_scl = c;
		bus_sda = d;
	endfunction

	function automatic void load_shift(logic [7:0] v);
		bus_shift = v;
		bus_bidx = '0;
		go_to(PH_TX_LOW, 1'b0, bus_sda);
	endfunction

	function automatic void next_tx_byte();
		logic [7:0] v;
		v = (data_ptr < BufDepth) ? wbuf[data_ptr] : 8'h00;
		data_ptr++;
		if (bus_left != 0) bus_left--;
		load_shift(v);
	endfunction

	// advance one tick; fills the receive, done and status fields of r
	function automatic void bus_step(logic s, inout res_t r);
		int dur;
		logic b;
		if (bus_ph == PH_IDLE) return;
		if (bus_ph == PH_TX_SETUP || bus_ph == PH_RXACK_SETUP) dur = setup_q;
		else dur = (half_q == 0) ? 1 : half_q;
		if (int'(bus_tcnt) + 1 < dur) begin
			bus_tcnt++;
			return;
		end
		case (bus_ph)
			PH_START_HI: go_to(PH_START_LO, 1'b1, 1'b0);
			PH_START_LO: begin
				go_to(PH_START_LO, 1'b0, 1'b0);
				load_shift(DevBase | {4'b0, bus_addr[10:8], 1'b0} | {7'b0, bus_stg == STG_DEV_R});
			end
			PH_TX_LOW: begin
				b = bus_shift[7];
				if (setup_q != 0) go_to(PH_TX_SETUP, 1'b0, b);
				else go_to(PH_TX_HIGH, 1'b1, b);
			end
			PH_TX_SETUP: go_to(PH_TX_HIGH, 1'b1, bus_sda);
			PH_TX_HIGH: begin
				bus_shift = bus_shift << 1;
				bus_bidx++;
				if (bus_bidx >= 8) go_to(PH_TXACK_LOW, 1'b0, bus_sda);
				else go_to(PH_TX_LOW, 1'b0, bus_sda);
			end
			PH_TXACK_LOW: go_to(PH_TXACK_HIGH, 1'b1, 1'b1);
			PH_TXACK_HIGH: begin
				if (s) begin
					// slave refused: abort with STOP
					bus_failed = 1'b1;
					go_to(PH_STOP_LOW, 1'b0, 1'b0);
				end else begin
					go_to(PH_TXACK_HIGH, 1'b0, 1'b1);
					case (bus_stg)
						STG_DEV_W: begin
							bus_stg = STG_ADDR_LO;
							load_shift(bus_addr[7:0]);
						end
						STG_ADDR_LO: begin
							if (bus_rd) begin
								bus_stg = STG_DEV_R;
								go_to(PH_RESTART_LOW, 1'b0, 1'b1);
							end else begin
								bus_stg = STG_DATA;
								next_tx_byte();
							end
						end
						STG_DATA: begin
							if (bus_left == 0) go_to(PH_STOP_LOW, 1'b0, 1'b0);
							else next_tx_byte();
						end
						default: begin
							bus_bidx = '0;
							go_to(PH_RX_LOW, 1'b0, 1'b1);
						end
					endcase
				end
			end
			PH_RX_LOW: go_to(PH_RX_HIGH, 1'b1, 1'b1);
			PH_RX_HIGH: begin
				bus_shift = {bus_shift[6:0], s};
				bus_bidx++;
				if (bus_bidx >= 8) begin
					r.rvalid = 1'b1;
					r.rbyte = bus_shift;
					if (bus_left != 0) bus_left--;
					go_to(PH_RXACK_LOW, 1'b0, 1'b1);
				end else go_to(PH_RX_LOW, 1'b0, 1'b1);
			end
			PH_RXACK_LOW: begin
				// NACK the last byte, ACK the others
				b = (bus_left == 0);
				if (setup_q != 0) go_to(PH_RXACK_SETUP, 1'b0, b);
				else go_to(PH_RXACK_HIGH, 1'b1, b);
			end
			PH_RXACK_SETUP: go_to(PH_RXACK_HIGH, 1'b1, bus_sda);
			PH_RXACK_HIGH: begin
				if (bus_left == 0) go_to(PH_STOP_LOW, 1'b0, 1'b0);
				else begin
					bus_bidx = '0;
					go_to(PH_RX_LOW, 1'b0, 1'b1);
				end
			end
			PH_RESTART_LOW: go_to(PH_START_HI, 1'b1, 1'b1);
			PH_STOP_LOW: go_to(PH_STOP_HIGH, 1'b1, 1'b0);
			default: begin
				r.done = 1'b1;
				r.status = bus_failed;
				if (!bus_rd) fill_ptr = 0;
				go_to(PH_IDLE, 1'b1, 1'b1);
			end
		endcase
	endfunction

	function automatic res_t predict_beat(logic [1:0] o, logic [10:0] a, logic [9:0] c,
			logic [7:0] w, logic s);
		res_t r;
		int n;
		r = '0;
		r.scl = bus_scl;
		r.sda = bus_sda;
		if (o == OP_TICK) begin
			bus_step(s, r);
		end else if (bus_ph == PH_IDLE) begin
			if (o == OP_PUSH) begin
				if (fill_ptr < BufDepth) begin
					wbuf[fill_ptr] = w;
					fill_ptr++;
					if (fill_ptr > pushed_hi) pushed_hi = fill_ptr;
				end
			end else begin
				n = (c == 0) ? 1 : ((c > BufDepth) ? BufDepth : int'(c));
				bus_addr = a;
				bus_left = 10'(n);
				bus_rd = (o == OP_READ);
				data_ptr = 0;
				bus_stg = STG_DEV_W;
				bus_failed = 1'b0;
				bus_bidx = '0;
				go_to(PH_START_HI, 1'b1, 1'b1);
			end
			r.scl = bus_scl;
			r.sda = bus_sda;
		end
		r.busy = (bus_ph != PH_IDLE);
		return r;
	endfunction

	initial begin
		half_q = HalfResetVal;
		setup_q = SetupResetVal;
		bus_ph = PH_IDLE;
		bus_stg = STG_DEV_W;
		bus_tcnt = '0;
		bus_bidx = '0;
		bus_shift = '0;
		bus_left = '0;
		bus_addr = '0;
		bus_rd = 1'b0;
		bus_scl = 1'b1;
		bus_sda = 1'b1;
		bus_failed = 1'b0;
		fill_ptr = 0;
		data_ptr = 0;
		pushed_hi = 0;
	end

	// ---------------- scoreboard ----------------
	always @(posedge clk) begin
		res_t got, want, nxt;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_HALF) half_q = cfg_wdata;
				else setup_q = cfg_wdata;
			end
			// retire the oldest expectation before queuing the newly accepted item
			if (out_valid && out_ready) begin
				got = '{scl_out, sda_out, read_byte, read_valid, done_res, status, busy_res};
				if (beat_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result beat %p", got);
				end else begin
					want = beat_q.pop_front();
					if (got.scl !== want.scl || got.sda !== want.sda
							|| got.rbyte !== want.rbyte || got.rvalid !== want.rvalid
							|| got.done !== want.done || got.status !== want.status
							|| got.busy !== want.busy) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (in_valid && in_ready) begin
				nxt = predict_beat(op, mem_address, byte_count, write_byte, sda_in);
				if (typed_on) nxt = typed_res;
				beat_q.push_back(nxt);
				accepted++;
			end
		end
	end

	// Receiver: hold ready low for the configured share of cycles.
	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

	// ---------------- stimulus ----------------
	int sent = 0;

	// Valid stays high after acceptance until the next beat or an explicit drop,
	// so that each falling edge assigns it at most once.
	task automatic send_beat(logic [1:0] o, logic [10:0] a, logic [9:0] c, logic [7:0] w,
			logic s, bit tv = 1'b0, res_t tr = '0);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		mem_address <= a;
		byte_count <= c;
		write_byte <= w;
		sda_in <= s;
		typed_on <= tv;
		typed_res <= tr;
		sent++;
		// hold the beat until the scoreboard has seen it accepted
		do @(negedge clk); while (accepted != sent);
	endtask

	// SDA for the next tick: refuse at an ACK slot by the given percentage, random elsewhere
	function automatic logic line_level(int nack_pct);
		if (bus_ph == PH_TXACK_HIGH) return ($urandom_range(99) < nack_pct);
		return 1'($urandom_range(1));
	endfunction

	// tick until the transfer ends, with an occasional ignored command while busy
	task automatic drain_bus(int nack_pct);
		while (bus_ph != PH_IDLE) begin
			if ($urandom_range(99) < 3)
				send_beat(2'($urandom_range(3, 1)), 11'($urandom), 10'($urandom),
					8'($urandom), 1'($urandom));
			else
				send_beat(OP_TICK, 11'($urandom), 10'($urandom), 8'($urandom),
					line_level(nack_pct));
		end
	endtask

	task automatic write_regs(logic [15:0] h, logic [15:0] s);
		in_valid <= 1'b0;
		wait (beat_q.size() == 0);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HALF;
		cfg_wdata <= h;
		@(negedge clk);
		cfg_index <= CFG_SETUP;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_transfer(bit fast);
		int k, n, c;
		k = $urandom_range(99);
		if (k < 40) begin
			n = $urandom_range(4, 1);
			repeat (n) send_beat(OP_PUSH, 11'($urandom), 10'($urandom), 8'($urandom),
				1'($urandom));
			c = $urandom_range((pushed_hi < 3) ? pushed_hi : 3, 1);
			if ($urandom_range(9) == 0) c = 0;
			send_beat(OP_WRITE, 11'($urandom), 10'(c), 8'($urandom), 1'($urandom));
			drain_bus(3);
		end else if (k < 75) begin
			// now and then a zero count, which reads one byte
			c = (fast && $urandom_range(9) == 0) ? 0 : $urandom_range(2, 1);
			send_beat(OP_READ, 11'($urandom), 10'(c), 8'($urandom), 1'($urandom));
			drain_bus(3);
		end else begin
			// noise: loose commands and ticks, some of which start a transfer
			repeat (5) begin
				k = $urandom_range(3);
				c = $urandom_range(1023);
				if (k == OP_WRITE && bus_ph == PH_IDLE)
					c = $urandom_range((pushed_hi < 3) ? pushed_hi : 3, 0);
				else if (k == OP_READ && bus_ph == PH_IDLE)
					c = $urandom_range(2);
				send_beat(2'(k), 11'($urandom), 10'(c), 8'($urandom), line_level(20));
			end
			drain_bus(10);
		end
	endtask

	task automatic random_phase(int budget, bit fast);
		int stop_at;
		stop_at = sent + budget;
		while (sent < stop_at) random_transfer(fast);
	endtask

	typedef struct {
		logic [1:0] o;
		logic [10:0] a;
		logic [9:0] c;
		logic [7:0] w;
		logic s;
		bit tv;
		res_t r;
	} row_t;

	localparam res_t IdleBeat = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam res_t BusyBeat = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};

	// Reset timing: idle ticks, pushes of both byte extremes, a write at the top
	// address with a zero count, then commands that must be ignored while busy.
	row_t opening [] = '{
		'{OP_TICK,  11'h000, 10'd0,   8'h00, 1'b0, 1'b1, IdleBeat},
		'{OP_TICK,  11'h7FF, 10'd1023, 8'hFF, 1'b1, 1'b1, IdleBeat},
		'{OP_PUSH,  11'h000, 10'd0,   8'hFF, 1'b0, 1'b1, IdleBeat},
		'{OP_PUSH,  11'h000, 10'd0,   8'h00, 1'b1, 1'b1, IdleBeat},
		'{OP_PUSH,  11'h555, 10'd5,   8'hA5, 1'b0, 1'b1, IdleBeat},
		'{OP_WRITE, 11'h7FF, 10'd0,   8'h00, 1'b0, 1'b1, BusyBeat},
		'{OP_PUSH,  11'h000, 10'd0,   8'h3C, 1'b0, 1'b1, BusyBeat},
		'{OP_READ,  11'h000, 10'd3,   8'h00, 1'b0, 1'b1, BusyBeat},
		'{OP_WRITE, 11'h2AA, 10'd2,   8'h00, 1'b1, 1'b1, BusyBeat}
	};

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phase 1: sender rarely idle, receiver often
		send_idle = 8;
		recv_idle = 53;
		foreach (opening[i])
			send_beat(opening[i].o, opening[i].a, opening[i].c, opening[i].w, opening[i].s,
				opening[i].tv, opening[i].r);
		// short timing from here; the write begun at reset timing runs out with it
		write_regs(16'd1, 16'd0);
		drain_bus(0);
		send_beat(OP_READ, 11'h000, 10'd2, 8'h00, 1'b0, 1'b1, BusyBeat);
		drain_bus(0);

		// zero half period and zero setup: a short write, a one-byte read at the top
		write_regs(16'd0, 16'd0);
		repeat (2) send_beat(OP_PUSH, 11'($urandom), 10'($urandom), 8'($urandom),
			1'($urandom));
		send_beat(OP_WRITE, 11'($urandom), 10'd2, 8'h00, 1'b0);
		drain_bus(0);
		send_beat(OP_READ, 11'h7FF, 10'd1, 8'h00, 1'b0);
		drain_bus(0);
		// slave refuses the device byte of a write, then refuses a read at random ACK slots
		send_beat(OP_PUSH, 11'h000, 10'd0, 8'h81, 1'b0);
		send_beat(OP_WRITE, 11'h123, 10'd1, 8'h00, 1'b0);
		drain_bus(100);
		send_beat(OP_READ, 11'h456, 10'd2, 8'h00, 1'b0);
		drain_bus(40);
		random_phase(40, 1'b1);

		// largest register values: only idle traffic fits at this timing
		write_regs(16'hFFFF, 16'hFFFF);
		repeat (20) send_beat($urandom_range(1) ? OP_TICK : OP_PUSH,
			11'($urandom), 10'($urandom), 8'($urandom), 1'($urandom));

		// phase 2: sender often idle, receiver rarely
		send_idle = 53;
		recv_idle = 8;
		write_regs(16'd1, 16'd1);
		random_phase(70, 1'b1);
		write_regs(16'd1, 16'd0);
		random_phase(50, 1'b1);

		// phase 3: no idling on either side
		send_idle = 0;
		recv_idle = 0;
		write_regs(16'd1, 16'd2);
		random_phase(90, 1'b0);

		in_valid <= 1'b0;
		wait (beat_q.size() == 0);
		repeat (6) @(negedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	// Timeout: far beyond the slowest correct run.
	initial begin
		#(12 * 400000);
		$display("== FAIL ==");
		$finish;
	end
endmodule
